>>> rtl/stereo_spread_delay_top_assert.svh
// ----------------------------------------------------------------------------
// stereo spread delay assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef STEREO_SPREAD_DELAY_TOP_ASSERT_SVH
`define STEREO_SPREAD_DELAY_TOP_ASSERT_SVH

// same-cycle implication
`define SSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// shared constants for the stereo spread delay
// ----------------------------------------------------------------------------
package ssd_pkg;

    // default store depth and sample width
    localparam int SSD_STORE_DEPTH = 131072;
    localparam int SSD_SAMPLE_BITS = 16;

    // delay register width, also the widest configuration register
    localparam int DELAY_BITS = 18;

    // steps of the delay reduction and their counter
    localparam int RED_STEPS_N  = 3;
    localparam int RED_CNT_BITS = $clog2(RED_STEPS_N + 1);

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DELAY_SAMPLES  = 1'b0,
        CFG_INVERT_DELAYED = 1'b1
    } cfg_idx_t;

endpackage

>>> rtl/stereo_spread_delay_top.sv
// an input is registered in the memory read stage, then in the output register
// throughput: one stereo pair per cycle unless the output stalls, set by the
// dual-port delay memory; after reset the memory is cleared one entry per cycle
// a delay write reduces the delay modulo STORE_DEPTH
// no input is accepted during the clearing pass or the delay reduction
// reset is synchronous, active low, and clears all control state
// ----------------------------------------------------------------------------
// stereo_spread_delay_top
// haas-style stereo widener: one channel runs through a circular delay
// memory, the other passes straight through
// ----------------------------------------------------------------------------

`include "stereo_spread_delay_top_assert.svh"

module stereo_spread_delay_top
    import ssd_pkg::*;
#(
    parameter int STORE_DEPTH = SSD_STORE_DEPTH,
    parameter int SAMPLE_BITS = SSD_SAMPLE_BITS,
    localparam int DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [DATA_BITS-1:0]    s_tdata,     // left_in, right_in, zero pad

    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DATA_BITS-1:0]    m_tdata,     // left_out, right_out, zero pad

    // configuration write port
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_addr,
    input  logic [DELAY_BITS-1:0]   cfg_wr_data
);

    // address width of the delay memory and one bit more for sums
    localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int AWP = AW + 1;
    localparam logic [AWP-1:0] DEPTH_W  = AWP'(STORE_DEPTH);
    localparam logic [AW-1:0]  POS_LAST = AW'(STORE_DEPTH - 1);
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [RED_CNT_BITS-1:0] RED_STEPS = RED_CNT_BITS'(RED_STEPS_N);
    localparam int PAD_BITS = DATA_BITS - 2 * SAMPLE_BITS;

    // delay reduction by reciprocal multiplication: the quotient estimate is
    // at most one low, so one compare and subtract finishes the remainder
    localparam int RB  = DELAY_BITS + 2;
    localparam int PW  = DELAY_BITS + RB;
    localparam int RSH = DELAY_BITS + AW;
    localparam int RW  = (AWP > DELAY_BITS) ? AWP : DELAY_BITS;
    localparam logic [63:0]   RECIP_FULL = (64'd1 << RSH) / 64'(STORE_DEPTH);
    localparam logic [RB-1:0] RECIP      = RB'(RECIP_FULL);
    localparam logic [RW-1:0] DEPTH_R    = RW'(STORE_DEPTH);

    // ------------------------------------------------------------------
    // configuration and control state
    // ------------------------------------------------------------------
    logic [DELAY_BITS-1:0]   delay_reg;      // signed delay, sign picks channel
    logic                    invert_reg;
    logic [AW-1:0]           rem_reg;        // |delay| mod STORE_DEPTH
    logic [DELAY_BITS-1:0]   mag_reg;        // |delay| being reduced
    logic [PW-1:0]           prod_reg;       // |delay| times the reciprocal
    logic [DELAY_BITS-1:0]   qd_reg;         // quotient estimate times depth
    logic [RED_CNT_BITS-1:0] red_cnt_reg;
    logic                    red_busy_reg;
    logic                    clear_reg;      // clearing pass running
    logic [AW-1:0]           clr_addr_reg;
    logic [AW-1:0]           pos_reg;        // read position

    // stage 1: memory read in flight
    logic                    v1_reg;
    logic [SAMPLE_BITS-1:0]  rd_reg;
    logic                    fwd_reg;        // write hit the read slot
    logic [SAMPLE_BITS-1:0]  fwd_data_reg;
    logic [SAMPLE_BITS-1:0]  pass_reg;       // undelayed channel
    logic                    left_sel_reg;   // left channel is the delayed one

    // stage 2: output register
    logic                    v2_reg;
    logic [SAMPLE_BITS-1:0]  out_left_reg;
    logic [SAMPLE_BITS-1:0]  out_right_reg;

    // delay memory, port a writes samples or clears, port b reads and clears
    logic [SAMPLE_BITS-1:0]  delay_mem [STORE_DEPTH];

    // ------------------------------------------------------------------
    // combinational datapath
    // ------------------------------------------------------------------
    logic                    s_accept;
    logic                    adv1;
    logic [SAMPLE_BITS-1:0]  left_in;
    logic [SAMPLE_BITS-1:0]  right_in;
    logic                    delay_left;
    logic [SAMPLE_BITS-1:0]  chosen;
    logic [SAMPLE_BITS-1:0]  stored;
    logic [AWP-1:0]          wr_sum;
    logic [AW-1:0]           wr_addr;
    logic                    same_slot;
    logic                    a_we;
    logic [AW-1:0]           a_addr;
    logic [SAMPLE_BITS-1:0]  a_data;
    logic [DELAY_BITS-1:0]   cfg_mag;
    logic [DELAY_BITS-1:0]   quot_est;
    logic [RW-1:0]           red_diff;
    logic [AW-1:0]           rem_next;
    logic [SAMPLE_BITS-1:0]  delayed;

    assign left_in  = s_tdata[SAMPLE_BITS-1:0];
    assign right_in = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // stage 1 hands on when the output register is free or being drained
    assign adv1     = v1_reg && (!v2_reg || m_tready);
    assign s_tready = !clear_reg && !red_busy_reg && (!v1_reg || adv1);
    assign s_accept = s_tvalid && s_tready;

    assign delay_left = delay_reg[DELAY_BITS-1];
    assign chosen     = delay_left ? left_in : right_in;

    // negation saturates the most negative sample
    always_comb begin
        if (!invert_reg) begin
            stored = chosen;
        end else if (chosen == SMP_MIN) begin
            stored = SMP_MAX;
        end else begin
            stored = SAMPLE_BITS'(~chosen + 1'b1);
        end
    end

    // write slot: position plus reduced delay, wrapped once
    assign wr_sum    = {1'b0, pos_reg} + {1'b0, rem_reg};
    assign wr_addr   = (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : wr_sum[AW-1:0];
    assign same_slot = (wr_addr == pos_reg);

    // a sample aimed at the slot being read leaves through the forward path
    assign a_we   = clear_reg || (s_accept && !same_slot);
    assign a_addr = clear_reg ? clr_addr_reg : wr_addr;
    assign a_data = clear_reg ? '0 : stored;

    // magnitude of a new delay value, -2^17 gives 2^17
    assign cfg_mag = cfg_wr_data[DELAY_BITS-1] ? DELAY_BITS'(~cfg_wr_data + 1'b1)
                                               : cfg_wr_data;

    // remainder from the quotient estimate, one correction step
    assign quot_est = DELAY_BITS'(prod_reg >> RSH);
    assign red_diff = RW'(mag_reg) - RW'(qd_reg);
    assign rem_next = (red_diff >= DEPTH_R) ? AW'(red_diff - DEPTH_R)
                                            : red_diff[AW-1:0];

    // same-slot write and read: the fresh sample comes out
    assign delayed = fwd_reg ? fwd_data_reg : rd_reg;

    // ------------------------------------------------------------------
    // delay memory
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (a_we) begin
            delay_mem[a_addr] <= a_data;
        end
        // read-first port: old contents out, slot cleared
        if (s_accept) begin
            rd_reg             <= delay_mem[pos_reg];
            delay_mem[pos_reg] <= '0;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg    <= '0;
            invert_reg   <= 1'b0;
            rem_reg      <= '0;
            mag_reg      <= '0;
            prod_reg     <= '0;
            qd_reg       <= '0;
            red_cnt_reg  <= '0;
            red_busy_reg <= 1'b0;
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
            pos_reg      <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end else begin
            // clearing pass after reset
            if (clear_reg) begin
                if (clr_addr_reg == POS_LAST) begin
                    clear_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end

            // configuration writes, a delay write restarts the reduction
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_DELAY_SAMPLES: begin
                        delay_reg    <= cfg_wr_data;
                        mag_reg      <= cfg_mag;
                        rem_reg      <= '0;
                        red_cnt_reg  <= RED_STEPS;
                        red_busy_reg <= 1'b1;
                    end
                    CFG_INVERT_DELAYED: begin
                        invert_reg <= cfg_wr_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            // multiply, multiply back, then subtract and correct
            if (red_busy_reg && !(cfg_wr_en && cfg_addr == CFG_DELAY_SAMPLES)) begin
                prod_reg    <= PW'(mag_reg) * PW'(RECIP);
                qd_reg      <= DELAY_BITS'(quot_est * DEPTH_W);
                red_cnt_reg <= red_cnt_reg - 1'b1;
                if (red_cnt_reg == RED_CNT_BITS'(1)) begin
                    rem_reg      <= rem_next;
                    red_busy_reg <= 1'b0;
                end
            end

            // read position advances once per transaction
            if (s_accept) begin
                pos_reg <= (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            end

            // pipeline valid bits
            if (s_accept) begin
                v1_reg <= 1'b1;
            end else if (adv1) begin
                v1_reg <= 1'b0;
            end
            if (adv1) begin
                v2_reg <= 1'b1;
            end else if (m_tready) begin
                v2_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_reg      <= same_slot;
            fwd_data_reg <= stored;
            pass_reg     <= delay_left ? right_in : left_in;
            left_sel_reg <= delay_left;
        end
        if (adv1) begin
            out_left_reg  <= left_sel_reg ? delayed : pass_reg;
            out_right_reg <= left_sel_reg ? pass_reg : delayed;
        end
    end

    assign m_tvalid = v2_reg;
    generate
        if (PAD_BITS > 0) begin : g_pad
            assign m_tdata = {{PAD_BITS{1'b0}}, out_right_reg, out_left_reg};
        end else begin : g_nopad
            assign m_tdata = {out_right_reg, out_left_reg};
        end
    endgenerate

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SSD_ASSERT_NEXT(a_pos_step, aclk, aresetn, s_accept,
        pos_reg == (($past(pos_reg) == POS_LAST) ? '0 : $past(pos_reg) + 1'b1),
        "read position did not advance by one")
    `SSD_ASSERT_IMPL(a_rem_range, aclk, aresetn, 1'b1, rem_reg < DEPTH_W[AW-1:0] ||
        DEPTH_W[AW], "reduced delay out of range")
    `SSD_ASSERT_NEXT(a_clear_once, aclk, aresetn, !clear_reg, !clear_reg,
        "clearing pass restarted without reset")
    `SSD_ASSERT_NEXT(a_stage_move, aclk, aresetn, adv1, v2_reg,
        "stage 1 item lost on its way to the output register")

endmodule

>>> tb/tb_stereo_spread_delay_top.sv
// ----------------------------------------------------------------------------
// tb_stereo_spread_delay_top
// self-checking bench for the stereo spread delay: a directed table of
// sample pairs and register writes, then randomized phases, each result
// checked against a given expectation or a bit-accurate delay line predictor
// ----------------------------------------------------------------------------

module tb_stereo_spread_delay_top;
    import ssd_pkg::*;

    localparam int DEPTH     = SSD_STORE_DEPTH;
    localparam int SMP_BITS  = SSD_SAMPLE_BITS;
    localparam int DATA_BITS = ((2 * SMP_BITS + 7) / 8) * 8;
    localparam int N_PHASES  = 12;
    localparam int PHASE_LEN = 75;
    localparam int SETTLE    = 4;        // margin after the last result
    localparam int N_ROWS    = 31;

    localparam logic [SMP_BITS-1:0] S_MIN  = 16'h8000;
    localparam logic [SMP_BITS-1:0] S_MAX  = 16'h7fff;
    localparam logic [SMP_BITS-1:0] S_ZERO = 16'h0000;
    localparam logic [SMP_BITS-1:0] S_NEG1 = 16'hffff;

    // directed table row: either a sample pair or a register write
    typedef enum logic {ROW_PAIR, ROW_REG} row_kind_t;
    typedef struct packed {
        row_kind_t             kind;
        cfg_idx_t              idx;
        logic [DELAY_BITS-1:0] val;
        logic [SMP_BITS-1:0]   l;
        logic [SMP_BITS-1:0]   r;
        logic                  typed;    // expected pair given literally
        logic [SMP_BITS-1:0]   exp_l;
        logic [SMP_BITS-1:0]   exp_r;
    } dir_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [DATA_BITS-1:0]    s_tdata = '0;        // left_in, right_in
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [DATA_BITS-1:0]    m_tdata;             // left_out, right_out
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_addr = CFG_DELAY_SAMPLES;
    logic [DELAY_BITS-1:0]   cfg_wr_data = '0;

    // predictor state: delay line contents, read pointer and registers
    logic [SMP_BITS-1:0]          line_mem [DEPTH];
    int unsigned                  rd_ptr = 0;
    logic signed [DELAY_BITS-1:0] delay_reg = '0;
    logic                         invert_reg = 1'b0;

    // expected output pairs, oldest first: {right, left}
    logic [2*SMP_BITS-1:0] pending_out [$];
    logic [2*SMP_BITS-1:0] exp_pair;

    int mismatch_cnt  = 0;
    int pairs_sent    = 0;
    int pairs_checked = 0;
    int reg_writes    = 0;
    int burst_left    = 0;
    int stall_mode    = 0;
    int stall_span    = 0;
    int stall_tick    = 0;

    // directed table: reset state, saturation, delay wrap, both channels
    dir_row_t dir_rows [N_ROWS] = '{
        // reset registers: delay 0, no inversion, everything passes
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h7fff, 16'h8000, 1'b1, 16'h7fff, 16'h8000},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h8000, 16'h7fff, 1'b1, 16'h8000, 16'h7fff},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'hffff, 16'h0001, 1'b1, 16'hffff, 16'h0001},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h5555, 16'haaaa, 1'b1, 16'h5555, 16'haaaa},
        // invert with all upper bits set, only bit 0 counts
        '{ROW_REG, CFG_INVERT_DELAYED, 18'h3ffff, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
        // right negated in place, most negative saturates
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h8000, 16'h8000, 1'b1, 16'h8000, 16'h7fff},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h7fff, 16'h7fff, 1'b1, 16'h7fff, 16'h8001},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h0001, 16'h0000, 1'b1, 16'h0001, 16'h0000},
        // most negative delay: left channel, magnitude wraps to zero
        '{ROW_REG, CFG_DELAY_SAMPLES, 18'h20000, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h8000, 16'h0005, 1'b1, 16'h7fff, 16'h0005},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h0064, 16'hff9c, 1'b1, 16'hff9c, 16'hff9c},
        // invert off via bit 0 clear, short right delay
        '{ROW_REG, CFG_INVERT_DELAYED, 18'h00002, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DELAY_SAMPLES, 18'h00003, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h1234, 16'h8000, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h7fff, 16'h4321, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h8000, 16'hffff, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h0000, 16'h7fff, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'habcd, 16'h0001, 1'b0, 16'h0, 16'h0},
        // short left delay, leftover right samples stay in the line
        '{ROW_REG, CFG_DELAY_SAMPLES, 18'h3fffe, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h7fff, 16'h8000, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h8000, 16'h1111, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h0f0f, 16'hf0f0, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'hffff, 16'h2222, 1'b0, 16'h0, 16'h0},
        // largest positive delay and its negative, inverted
        '{ROW_REG, CFG_INVERT_DELAYED, 18'h00001, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DELAY_SAMPLES, 18'h1ffff, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h8000, 16'h8000, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h7fff, 16'h0000, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DELAY_SAMPLES, 18'h20001, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h8000, 16'h0000, 1'b0, 16'h0, 16'h0},
        '{ROW_PAIR, CFG_DELAY_SAMPLES, 18'h0, 16'h1357, 16'h2468, 1'b0, 16'h0, 16'h0}
    };

    stereo_spread_delay_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // delay line starts cleared, as after the hardware clearing pass
    initial begin
        foreach (line_mem[i]) line_mem[i] = '0;
    end

    // one step of the widener: store the chosen channel ahead of the read
    // pointer, read and clear the slot under the pointer, advance it
    function automatic logic [2*SMP_BITS-1:0] spread_step(input logic [SMP_BITS-1:0] l,
                                                          input logic [SMP_BITS-1:0] r);
        logic                delay_left;
        int                  dly;
        int unsigned         mag;
        int unsigned         wr_ptr;
        logic [SMP_BITS-1:0] chosen;
        logic [SMP_BITS-1:0] delayed;
        dly        = int'(delay_reg);
        delay_left = (dly < 0);
        mag        = delay_left ? -dly : dly;
        wr_ptr     = (rd_ptr + mag) % DEPTH;
        chosen     = delay_left ? l : r;
        if (invert_reg) begin
            // negating the most negative sample clips to the top
            chosen = (chosen == S_MIN) ? S_MAX : -chosen;
        end
        line_mem[wr_ptr] = chosen;
        delayed          = line_mem[rd_ptr];
        line_mem[rd_ptr] = '0;
        rd_ptr           = (rd_ptr + 1) % DEPTH;
        return delay_left ? {r, delayed} : {delayed, l};
    endfunction

    // present one pair, hold it until the transaction happens, then log
    // what should come out
    task automatic send_pair(input logic [SMP_BITS-1:0] l, input logic [SMP_BITS-1:0] r,
                             input logic typed, input logic [2*SMP_BITS-1:0] typed_pair);
        logic [2*SMP_BITS-1:0] predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_BITS - 2*SMP_BITS){1'b0}}, r, l};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = spread_step(l, r);
        pending_out.push_back(typed ? typed_pair : predicted);
        pairs_sent++;
    endtask

    // burst pacing: random burst lengths, random gaps, some gapless bursts
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // register write, enable left high so writes can go back to back;
    // the caller lowers it afterwards
    task automatic write_reg(input cfg_idx_t idx, input logic [DELAY_BITS-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            CFG_DELAY_SAMPLES:  delay_reg  = val;
            CFG_INVERT_DELAYED: invert_reg = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    function automatic logic [SMP_BITS-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return S_ZERO;
            3:       return S_NEG1;
            default: return SMP_BITS'($urandom);
        endcase
    endfunction

    // mostly short delays so the delayed samples show up inside a phase
    function automatic logic [DELAY_BITS-1:0] rand_delay();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       return 18'h1ffff;      // largest positive
                    1:       return 18'h20001;      // negative of the largest positive
                    2:       return 18'h20000;      // wraps to zero, left side
                    3:       return 18'h00000;
                    4:       return 18'h00001;
                    default: return 18'h3ffff;      // minus one
                endcase
            end
            1:       return DELAY_BITS'($urandom);
            default: return DELAY_BITS'($urandom_range(0, 80) - 40);
        endcase
    endfunction

    // receiver back-pressure: pattern picked anew each time its span runs out
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 1;
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(50, 200);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ((stall_tick % 5) >= 2);
        endcase
    end

    // result checker: each result transaction against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected result, left %0d right %0d", $time,
                         $signed(m_tdata[SMP_BITS-1:0]),
                         $signed(m_tdata[2*SMP_BITS-1:SMP_BITS]));
            end else begin
                exp_pair = pending_out.pop_front();
                pairs_checked++;
                if (m_tdata[SMP_BITS-1:0] !== exp_pair[SMP_BITS-1:0]) begin
                    mismatch_cnt++;
                    $display("%0t: left_out expected %0d actual %0d", $time,
                             $signed(exp_pair[SMP_BITS-1:0]),
                             $signed(m_tdata[SMP_BITS-1:0]));
                end
                if (m_tdata[2*SMP_BITS-1:SMP_BITS] !== exp_pair[2*SMP_BITS-1:SMP_BITS]) begin
                    mismatch_cnt++;
                    $display("%0t: right_out expected %0d actual %0d", $time,
                             $signed(exp_pair[2*SMP_BITS-1:SMP_BITS]),
                             $signed(m_tdata[2*SMP_BITS-1:SMP_BITS]));
                end
            end
        end
    end

    // main sequence
    initial begin
        logic prev_reg;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; the first pair waits out the clearing pass
        prev_reg = 1'b0;
        for (int i = 0; i < N_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_REG) begin
                if (!prev_reg) drain();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
                prev_reg = 1'b1;
            end else begin
                cfg_wr_en <= 1'b0;
                if (!prev_reg) pace_sender();
                send_pair(dir_rows[i].l, dir_rows[i].r, dir_rows[i].typed,
                          {dir_rows[i].exp_r, dir_rows[i].exp_l});
                prev_reg = 1'b0;
            end
        end

        // random phases, each with a fresh setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            // invert before delay, so no write lands in the delay reduction
            if (ph == 0 || $urandom_range(0, 1) == 1)
                write_reg(CFG_INVERT_DELAYED, DELAY_BITS'($urandom));
            write_reg(CFG_DELAY_SAMPLES, rand_delay());
            cfg_wr_en <= 1'b0;
            for (int k = 0; k < PHASE_LEN; k++) begin
                // once in a while hold off until the pipeline is empty
                if (k == PHASE_LEN / 2 && ph % 4 == 1) drain();
                pace_sender();
                send_pair(rand_sample(), rand_sample(), 1'b0, '0);
            end
        end

        drain();
        repeat (8) @(posedge aclk);

        $display("sent %0d stereo pairs, checked %0d results, %0d register writes",
                 pairs_sent, pairs_checked, reg_writes);
        $display("covered both delay sides, inversion with clipping, delay wrap and stalls");
        if (mismatch_cnt == 0) begin
            $display("tb_stereo_spread_delay_top passed");
        end else begin
            $display("tb_stereo_spread_delay_top failed");
        end
        $finish;
    end

    // watchdog: clearing pass plus the whole stream, many times over
    initial begin
        #(64'd8 * 64'd1_000_000);
        $display("tb_stereo_spread_delay_top failed");
        $finish;
    end

endmodule
